// ----- hw/rtl/sukt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sukt_pkg: shared types and constants of the sorted unique key table
// Record layout, request and status codes, and the default table size.
// ----------------------------------------------------------------------------
package sukt_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam int unsigned MAX_RESULTS     = 64;
	localparam int unsigned KEY_W           = 31;
	localparam int unsigned PHONE_W         = 34;
	localparam int unsigned CNT_W           = 7;
	localparam int unsigned REQ_W           = 2;
	localparam int unsigned STAT_W          = 3;
	localparam int unsigned S_DATA_W        = 72;
	localparam int unsigned M_DATA_W        = 80;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_POP    = 2'd2,
		REQ_LIST   = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_DUP     = 3'd1,
		STAT_MISSING = 3'd2,
		STAT_EMPTY   = 3'd3,
		STAT_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic               female;
		logic [PHONE_W-1:0] phone;
		logic [KEY_W-1:0]   key;
	} rec_t;

	localparam int unsigned REC_W = $bits(rec_t);

endpackage
`default_nettype wire

// ----- hw/rtl/sukt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sukt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sukt_ram #(
	parameter int unsigned WIDTH = sukt_pkg::REC_W,
	parameter int unsigned DEPTH = sukt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_unique_key_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_unique_key_table: sorted record store with unique keys
// Insert, remove by key, remove lowest and list over one record RAM, driven
// by a small sequencer around one shared key comparator.
// ----------------------------------------------------------------------------
// A binary search of up to s = ceil(log2(fill+1)) steps, one RAM read and one compare
//   per step; insert and remove by key then shift the entries behind the position and
//   load the output register. Rejects go to the output state from the search, or from
//   idle on an empty table. Remove lowest reads the first record and shifts like a
//   remove; list emits one record at a time as the receiver takes them. One request
//   at a time, taken while idle. Reset clears every register, fill count included, not the RAM.
module sorted_unique_key_table #(
	parameter int unsigned TABLE_DEPTH = sukt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	// record_key[30:0], phone_number[64:31], is_female[65], zero pad
	input  wire logic [sukt_pkg::S_DATA_W-1:0] s_tdata,
	// req_type[1:0]
	input  wire logic [sukt_pkg::REQ_W-1:0]    s_tuser,
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	// out_key[30:0], out_phone[64:31], out_female[65], entry_count[72:66], zero pad
	output      logic [sukt_pkg::M_DATA_W-1:0] m_tdata,
	// status[2:0]
	output      logic [sukt_pkg::STAT_W-1:0]   m_tuser,
	output      logic                          m_tlast
);

	localparam int unsigned AW    = $clog2(TABLE_DEPTH);
	localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned CNT_W = sukt_pkg::CNT_W;
	localparam int unsigned PAD_W = sukt_pkg::M_DATA_W - sukt_pkg::REC_W - CNT_W;

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b00_0000_0001,
		ST_SRCH      = 10'b00_0000_0010,
		ST_SCMP      = 10'b00_0000_0100,
		ST_POP_RD    = 10'b00_0000_1000,
		ST_POP_LAT   = 10'b00_0001_0000,
		ST_INS_SHIFT = 10'b00_0010_0000,
		ST_DEL_SHIFT = 10'b00_0100_0000,
		ST_LIST_RD   = 10'b00_1000_0000,
		ST_LIST_WAIT = 10'b01_0000_0000,
		ST_DONE      = 10'b10_0000_0000
	} state_t;

	state_t            state_q;
	sukt_pkg::req_t    req_q;
	sukt_pkg::status_t status_q;
	sukt_pkg::rec_t    new_rec_q;
	sukt_pkg::rec_t    rec_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     lo_q;
	logic [CW-1:0]     hi_q;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     idx_q;
	logic [AW-1:0]     mid_q;
	logic              eq_q;
	logic              mv_v_s1;
	logic [AW-1:0]     mv_addr_s1;

	logic              out_v_q;
	sukt_pkg::rec_t    out_rec_q;
	sukt_pkg::status_t out_st_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_last_q;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [sukt_pkg::REC_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [sukt_pkg::REC_W-1:0] ram_rdata;

	sukt_pkg::rec_t rd_rec;
	logic [CW-1:0]  mid_w;
	logic [CW-1:0]  cnt_m1;
	logic [CW-1:0]  lst_n;
	logic           lst_last;
	logic           out_free;
	logic           out_load;
	logic           accept;
	logic           key_lt;
	logic           emit_rec;

	assign rd_rec   = sukt_pkg::rec_t'(ram_rdata);
	assign mid_w    = lo_q + ((hi_q - lo_q) >> 1);
	assign cnt_m1   = cnt_q - 1'b1;
	assign lst_n    = (fill_q > sukt_pkg::MAX_RESULTS) ? CW'(sukt_pkg::MAX_RESULTS) : fill_q;
	assign lst_last = ({1'b0, idx_q} + 1'b1) == {1'b0, lst_n};
	assign out_free = !out_v_q || m_tready;
	assign out_load = out_free && ((state_q == ST_DONE) || (state_q == ST_LIST_WAIT));
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign key_lt   = rd_rec.key < new_rec_q.key;
	assign emit_rec = (status_q == sukt_pkg::STAT_OK) &&
		((req_q == sukt_pkg::REQ_REMOVE) || (req_q == sukt_pkg::REQ_POP));

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_cnt_q, out_rec_q};
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;

	sukt_ram #(
		.WIDTH(sukt_pkg::REC_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					ram_re    = 1'b1;
					ram_raddr = mid_w[AW-1:0];
				end
			end
			ST_POP_RD: begin
				ram_re = 1'b1;
			end
			ST_INS_SHIFT: begin
				if (mv_v_s1) begin
					ram_we    = 1'b1;
					ram_waddr = mv_addr_s1;
				end else if (cnt_q == pos_q) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[AW-1:0];
					ram_wdata = new_rec_q;
				end
				if (cnt_q != pos_q) begin
					ram_re    = 1'b1;
					ram_raddr = cnt_m1[AW-1:0];
				end
			end
			ST_DEL_SHIFT: begin
				if (mv_v_s1) begin
					ram_we    = 1'b1;
					ram_waddr = mv_addr_s1;
				end
				if (cnt_q < fill_q) begin
					ram_re    = 1'b1;
					ram_raddr = cnt_q[AW-1:0];
				end
			end
			ST_LIST_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			req_q      <= sukt_pkg::REQ_INSERT;
			status_q   <= sukt_pkg::STAT_OK;
			new_rec_q  <= '0;
			rec_q      <= '0;
			fill_q     <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			pos_q      <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
			mid_q      <= '0;
			eq_q       <= 1'b0;
			mv_v_s1    <= 1'b0;
			mv_addr_s1 <= '0;
			out_v_q    <= 1'b0;
			out_rec_q  <= '0;
			out_st_q   <= sukt_pkg::STAT_OK;
			out_cnt_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q     <= sukt_pkg::req_t'(s_tuser);
						new_rec_q <= sukt_pkg::rec_t'(s_tdata[sukt_pkg::REC_W-1:0]);
						lo_q      <= '0;
						hi_q      <= fill_q;
						eq_q      <= 1'b0;
						idx_q     <= '0;
						case (sukt_pkg::req_t'(s_tuser))
							sukt_pkg::REQ_INSERT: begin
								state_q <= ST_SRCH;
							end
							sukt_pkg::REQ_REMOVE: begin
								if (fill_q == '0) begin
									status_q <= sukt_pkg::STAT_EMPTY;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_SRCH;
								end
							end
							sukt_pkg::REQ_POP: begin
								if (fill_q == '0) begin
									status_q <= sukt_pkg::STAT_EMPTY;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_POP_RD;
								end
							end
							default: begin
								if (fill_q == '0) begin
									status_q <= sukt_pkg::STAT_EMPTY;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_LIST_RD;
								end
							end
						endcase
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_w[AW-1:0];
						state_q <= ST_SCMP;
					end else begin
						pos_q   <= lo_q;
						mv_v_s1 <= 1'b0;
						if (req_q == sukt_pkg::REQ_INSERT) begin
							if (eq_q) begin
								status_q <= sukt_pkg::STAT_DUP;
								state_q  <= ST_DONE;
							end else if (fill_q == CW'(TABLE_DEPTH)) begin
								status_q <= sukt_pkg::STAT_FULL;
								state_q  <= ST_DONE;
							end else begin
								cnt_q   <= fill_q;
								state_q <= ST_INS_SHIFT;
							end
						end else if (!eq_q) begin
							status_q <= sukt_pkg::STAT_MISSING;
							state_q  <= ST_DONE;
						end else begin
							cnt_q   <= lo_q + 1'b1;
							state_q <= ST_DEL_SHIFT;
						end
					end
				end
				ST_SCMP: begin
					if (key_lt) begin
						lo_q <= CW'(mid_q) + 1'b1;
					end else begin
						hi_q  <= CW'(mid_q);
						eq_q  <= (rd_rec.key == new_rec_q.key);
						rec_q <= rd_rec;
					end
					state_q <= ST_SRCH;
				end
				ST_POP_RD: begin
					state_q <= ST_POP_LAT;
				end
				ST_POP_LAT: begin
					rec_q   <= rd_rec;
					pos_q   <= '0;
					cnt_q   <= CW'(1);
					mv_v_s1 <= 1'b0;
					state_q <= ST_DEL_SHIFT;
				end
				ST_INS_SHIFT: begin
					if (cnt_q != pos_q) begin
						cnt_q      <= cnt_m1;
						mv_v_s1    <= 1'b1;
						mv_addr_s1 <= cnt_q[AW-1:0];
					end else begin
						mv_v_s1 <= 1'b0;
						if (!mv_v_s1) begin
							fill_q   <= fill_q + 1'b1;
							status_q <= sukt_pkg::STAT_OK;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_DEL_SHIFT: begin
					if (cnt_q < fill_q) begin
						cnt_q      <= cnt_q + 1'b1;
						mv_v_s1    <= 1'b1;
						mv_addr_s1 <= cnt_m1[AW-1:0];
					end else begin
						mv_v_s1 <= 1'b0;
						if (!mv_v_s1) begin
							fill_q   <= fill_q - 1'b1;
							status_q <= sukt_pkg::STAT_OK;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_LIST_RD: begin
					state_q <= ST_LIST_WAIT;
				end
				ST_LIST_WAIT: begin
					if (out_free) begin
						out_rec_q  <= rd_rec;
						out_st_q   <= sukt_pkg::STAT_OK;
						out_cnt_q  <= CNT_W'(fill_q);
						out_last_q <= lst_last;
						idx_q      <= idx_q + 1'b1;
						state_q    <= lst_last ? ST_IDLE : ST_LIST_RD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_rec_q  <= emit_rec ? rec_q : '0;
						out_st_q   <= status_q;
						out_cnt_q  <= CNT_W'(fill_q);
						out_last_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= TABLE_DEPTH)
		else $error("fill count beyond table depth");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second request taken while busy");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr <= fill_q))
		else $error("RAM write beyond occupied range");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |->
			((fill_q == $past(fill_q) + 1'b1) || (fill_q == $past(fill_q) - 1'b1)))
		else $error("fill count moved by more than one");

endmodule
`default_nettype wire

// ----- tb/tb_sorted_unique_key_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sorted_unique_key_table: self-checking bench for the sorted key table
// Streams insert, remove, pop and list requests into the table, predicts every
// result from a sorted roster kept in the bench, and compares each result
// field by field as it leaves, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_sorted_unique_key_table;

	import sukt_pkg::*;

	localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

	typedef struct {
		req_t op;
		rec_t rec;
	} pending_req_t;

	typedef struct {
		status_t          status;
		rec_t             rec;
		logic [CNT_W-1:0] count;
		logic             last;
	} roster_result_t;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [REQ_W-1:0]    s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]   m_tuser;
	logic                m_tlast;

	sorted_unique_key_table #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	pending_req_t     pending_reqs[$];
	pending_req_t     nxt_req;
	roster_result_t   due_results[$];
	roster_result_t   want;
	rec_t             got_rec;
	rec_t             roster_recs[DEPTH];
	int unsigned      roster_fill = 0;
	bit [KEY_W-1:0]   shadow_keys[$];

	int               n_errors    = 0;
	int               n_results   = 0;
	int               n_accepted  = 0;
	int               n_queued    = 0;
	int               n_dup       = 0;
	int               n_full      = 0;
	int               n_missing   = 0;
	int               op_count[4] = '{0, 0, 0, 0};

	int               burst_left  = 0;
	int               gap_left    = 0;
	int               hold_left   = 0;
	bit               hold_done   = 1'b0;
	int               stall_mode  = 0;
	int               mode_left   = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("MISMATCH %s: got %0h, want %0h (result %0d)", field, got, exp_val,
			n_results);
		n_errors++;
	endtask

	// Sorted roster update for one accepted request; queue the results it causes.
	task automatic roster_apply(input req_t op, input rec_t rq);
		int unsigned    pos;
		int unsigned    i;
		int unsigned    n;
		roster_result_t r;
		r.status = STAT_OK;
		r.rec    = '0;
		r.last   = 1'b1;
		pos = 0;
		while (pos < roster_fill && roster_recs[pos].key < rq.key) pos++;
		case (op)
			REQ_INSERT: begin
				if (pos < roster_fill && roster_recs[pos].key == rq.key) begin
					r.status = STAT_DUP;
					n_dup++;
				end else if (roster_fill >= DEPTH) begin
					r.status = STAT_FULL;
					n_full++;
				end else begin
					for (i = roster_fill; i > pos; i--) roster_recs[i] = roster_recs[i - 1];
					roster_recs[pos] = rq;
					roster_fill++;
				end
				r.count = roster_fill[CNT_W-1:0];
				due_results.push_back(r);
			end
			REQ_REMOVE, REQ_POP: begin
				if (op == REQ_POP) pos = 0;
				if (roster_fill == 0) begin
					r.status = STAT_EMPTY;
				end else if (op == REQ_REMOVE &&
						(pos >= roster_fill || roster_recs[pos].key != rq.key)) begin
					r.status = STAT_MISSING;
					n_missing++;
				end else begin
					r.rec = roster_recs[pos];
					for (i = pos; i + 1 < roster_fill; i++) roster_recs[i] = roster_recs[i + 1];
					roster_fill--;
				end
				r.count = roster_fill[CNT_W-1:0];
				due_results.push_back(r);
			end
			default: begin
				r.count = roster_fill[CNT_W-1:0];
				if (roster_fill == 0) begin
					r.status = STAT_EMPTY;
					due_results.push_back(r);
				end else begin
					n = (roster_fill < MAX_RESULTS) ? roster_fill : MAX_RESULTS;
					for (i = 0; i < n; i++) begin
						r.rec  = roster_recs[i];
						r.last = (i + 1 == n);
						due_results.push_back(r);
					end
				end
			end
		endcase
	endtask

	function automatic int shadow_find(input bit [KEY_W-1:0] k);
		foreach (shadow_keys[i]) if (shadow_keys[i] == k) return i;
		return -1;
	endfunction

	function automatic bit [PHONE_W-1:0] rand_phone();
		bit [63:0] raw;
		raw = {$urandom(), $urandom()} % 64'd10000000000;
		return raw[PHONE_W-1:0];
	endfunction

	function automatic bit [KEY_W-1:0] fresh_key();
		bit [KEY_W-1:0] k;
		do begin
			if ($urandom_range(0, 2) == 0) k = KEY_W'($urandom_range(0, 255));
			else k = KEY_W'($urandom());
		end while (shadow_find(k) >= 0);
		return k;
	endfunction

	function automatic bit [KEY_W-1:0] present_key();
		if (shadow_keys.size() == 0) return fresh_key();
		return shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
	endfunction

	task automatic queue_req(input req_t op, input bit [KEY_W-1:0] k,
			input bit [PHONE_W-1:0] ph, input bit fem);
		pending_req_t p;
		int           idx;
		int           lo;
		p.op         = op;
		p.rec.key    = k;
		p.rec.phone  = ph;
		p.rec.female = fem;
		idx = shadow_find(k);
		case (op)
			REQ_INSERT: if (idx < 0 && shadow_keys.size() < DEPTH) shadow_keys.push_back(k);
			REQ_REMOVE: if (idx >= 0) shadow_keys.delete(idx);
			REQ_POP: begin
				if (shadow_keys.size() != 0) begin
					lo = 0;
					foreach (shadow_keys[i]) if (shadow_keys[i] < shadow_keys[lo]) lo = i;
					shadow_keys.delete(lo);
				end
			end
			default: ;
		endcase
		pending_reqs.push_back(p);
	endtask

	task automatic queue_mix(input int n, input int ins_pct);
		int sel;
		repeat (n) begin
			sel = $urandom_range(0, 99);
			if (sel < ins_pct)
				queue_req(REQ_INSERT, fresh_key(), rand_phone(), 1'($urandom_range(0, 1)));
			else if (sel < ins_pct + 10)
				queue_req(REQ_INSERT, present_key(), rand_phone(), 1'($urandom_range(0, 1)));
			else if (sel < ins_pct + 35)
				queue_req(REQ_REMOVE, present_key(), rand_phone(), 1'($urandom_range(0, 1)));
			else if (sel < ins_pct + 42)
				queue_req(REQ_REMOVE, fresh_key(), rand_phone(), 1'($urandom_range(0, 1)));
			else if (sel < 92)
				queue_req(REQ_POP, KEY_W'($urandom()), rand_phone(), 1'($urandom_range(0, 1)));
			else
				queue_req(REQ_LIST, KEY_W'($urandom()), rand_phone(), 1'($urandom_range(0, 1)));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= REQ_INSERT;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() != 0) begin
				nxt_req = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {{(S_DATA_W - REC_W){1'b0}}, nxt_req.rec};
				s_tuser  <= nxt_req.op;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 12);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern; hold off once for a long stretch to back up the table.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
			stall_mode <= 0;
			mode_left  <= 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left  <= $urandom_range(20, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			if (!hold_done && n_accepted >= 30) begin
				hold_done <= 1'b1;
				hold_left <= 400;
				m_tready  <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				case (stall_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_accepted <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result, key", 64'(m_tdata[KEY_W-1:0]), '0);
				end else begin
					want    = due_results.pop_front();
					got_rec = m_tdata[REC_W-1:0];
					if (m_tuser !== want.status)
						report_mismatch("status", 64'(m_tuser), 64'(want.status));
					if (got_rec.key !== want.rec.key)
						report_mismatch("out_key", 64'(got_rec.key), 64'(want.rec.key));
					if (got_rec.phone !== want.rec.phone)
						report_mismatch("out_phone", 64'(got_rec.phone), 64'(want.rec.phone));
					if (got_rec.female !== want.rec.female)
						report_mismatch("out_female", 64'(got_rec.female),
							64'(want.rec.female));
					if (m_tdata[REC_W +: CNT_W] !== want.count)
						report_mismatch("entry_count", 64'(m_tdata[REC_W +: CNT_W]),
							64'(want.count));
					if (m_tlast !== want.last)
						report_mismatch("last", 64'(m_tlast), 64'(want.last));
				end
				n_results++;
			end
			if (s_tvalid && s_tready) begin
				roster_apply(req_t'(s_tuser), s_tdata[REC_W-1:0]);
				op_count[s_tuser]++;
				n_accepted <= n_accepted + 1;
			end
		end
	end

	initial begin
		queue_req(REQ_LIST,   '0,           '0,                1'b0);
		queue_req(REQ_POP,    '0,           '0,                1'b0);
		queue_req(REQ_REMOVE, 31'd5,        '0,                1'b0);
		queue_req(REQ_INSERT, 31'h7FFFFFFF, 34'd9999999999,    1'b1);
		queue_req(REQ_INSERT, '0,           '0,                1'b0);
		queue_req(REQ_INSERT, 31'd1000,     rand_phone(),      1'b1);
		queue_req(REQ_INSERT, '0,           34'd1234567890,    1'b1);
		queue_req(REQ_INSERT, 31'h7FFFFFFF, '0,                1'b0);
		queue_req(REQ_REMOVE, 31'd500,      '0,                1'b0);
		queue_req(REQ_LIST,   '0,           '0,                1'b0);
		queue_req(REQ_REMOVE, 31'd1000,     '0,                1'b0);
		queue_req(REQ_POP,    '0,           '0,                1'b0);
		queue_req(REQ_REMOVE, 31'h7FFFFFFF, '0,                1'b0);
		queue_req(REQ_REMOVE, 31'h7FFFFFFF, '0,                1'b0);
		queue_req(REQ_INSERT, 31'h55555555, 34'd5555555555,    1'b0);
		queue_req(REQ_INSERT, 31'h2AAAAAAA, 34'd8589934592,    1'b1);
		queue_req(REQ_INSERT, 31'd1,        34'd4294967295,    1'b1);
		queue_req(REQ_LIST,   '0,           '0,                1'b0);
		queue_req(REQ_REMOVE, 31'd3,        '0,                1'b0);
		queue_req(REQ_POP,    '0,           '0,                1'b0);
		queue_req(REQ_POP,    '0,           '0,                1'b0);
		queue_req(REQ_POP,    '0,           '0,                1'b0);
		queue_req(REQ_POP,    '0,           '0,                1'b0);

		queue_mix(12, 45);
		while (shadow_keys.size() < DEPTH)
			queue_req(REQ_INSERT, fresh_key(), rand_phone(), 1'($urandom_range(0, 1)));
		queue_req(REQ_INSERT, fresh_key(),   rand_phone(), 1'b1);
		queue_req(REQ_INSERT, present_key(), rand_phone(), 1'b0);
		queue_req(REQ_LIST,   '0,            '0,           1'b0);
		queue_req(REQ_REMOVE, fresh_key(),   '0,           1'b0);
		queue_req(REQ_REMOVE, present_key(), '0,           1'b0);
		queue_req(REQ_INSERT, fresh_key(),   rand_phone(), 1'b1);
		queue_req(REQ_INSERT, fresh_key(),   rand_phone(), 1'b0);
		queue_mix(8, 20);
		queue_req(REQ_LIST,   '0,            '0,           1'b0);
		n_queued = pending_reqs.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (n_accepted != n_queued || due_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Ran %0d requests: %0d insert, %0d remove, %0d pop, %0d list; %0d results",
			n_queued, op_count[REQ_INSERT], op_count[REQ_REMOVE], op_count[REQ_POP],
			op_count[REQ_LIST], n_results);
		$display("Rejects seen: %0d duplicate, %0d full-table, %0d key-not-found",
			n_dup, n_full, n_missing);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/sukt_pkg.sv
hw/rtl/sukt_ram.sv
hw/rtl/sorted_unique_key_table.sv
tb/tb_sorted_unique_key_table.sv
